// ----- sv/debounced_quadrature_decoder_top_assert.svh -----
// Assertion macros used by the decoder back end.
`ifndef DEBOUNCED_QUADRATURE_DECODER_TOP_ASSERT_SVH
`define DEBOUNCED_QUADRATURE_DECODER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DQD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DQD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dqd_pkg.sv -----
`timescale 1ns / 1ps
package dqd_pkg;

	localparam int unsigned TICK_WIDTH  = 16;
	localparam int unsigned POS_WIDTH   = 16;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [TICK_WIDTH-1:0] DEBOUNCE_RESET = 16'd5;
	localparam logic [TICK_WIDTH-1:0] TICK_MAX       = 16'hFFFF;

	// One classified tick request as it sits in the queue.
	typedef struct packed {
		logic enc_a;
		logic enc_b;
		logic button_in;
		logic acknowledge;
		logic rise;
		logic fall;
	} dqd_item_t;

endpackage

// ----- sv/debounced_quadrature_decoder_top.sv -----
`timescale 1ns / 1ps
// Channel    Dir  Handshake                  Payload
// s_axis     in   s_axis_tvalid/tready       tdata[3:0] enc_a, enc_b, button_in, acknowledge
// m_axis     out  m_axis_tvalid/tready       tdata[19:0] position, changed, clockwise, ...
// cfg        in   cfg_valid/cfg_ready        cfg_data = debounce_ticks
//
// One tick request per cycle is taken while the queue has room; its result appears in the cycle after
// it leaves the two-entry queue.
// The decoder state update is a single combinational step in the back end; that step sets the rate.
// Reset clears the counts, the wait state and the queue; debounce_ticks returns to 5.
// A stalled m_axis holds the output register while the queue takes requests until both
// of its entries are full.
module debounced_quadrature_decoder_top #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [0] enc_a, [1] enc_b, [2] button_in, [3] acknowledge, [7:4] zero
	input  logic [dqd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] position, [16] changed, [17] clockwise, [18] counterclockwise,
	// [19] button_level, [23:20] zero
	output logic [dqd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dqd_pkg::TICK_WIDTH-1:0]      cfg_data
);
	import dqd_pkg::*;

	logic      fq_valid;
	logic      fq_ready;
	dqd_item_t fq_item;
	logic      qb_valid;
	logic      qb_ready;
	dqd_item_t qb_item;

	assign cfg_ready = 1'b1;

	dqd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_data  (s_axis_tdata),
		.q_ready  (fq_ready),
		.in_ready (s_axis_tready),
		.q_valid  (fq_valid),
		.q_item   (fq_item)
	);

	dqd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_item  (fq_item),
		.push_ready (fq_ready),
		.pop_valid  (qb_valid),
		.pop_item   (qb_item),
		.pop_ready  (qb_ready)
	);

	dqd_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_valid   (qb_valid),
		.q_item    (qb_item),
		.q_ready   (qb_ready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_ready (m_axis_tready)
	);

endmodule

// ----- sv/dqd_front.sv -----
`timescale 1ns / 1ps
module dqd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [dqd_pkg::IN_TDATA_W-1:0]      in_data,
	input  logic                                q_ready,
	output logic                                in_ready,
	output logic                                q_valid,
	output dqd_pkg::dqd_item_t                  q_item
);
	import dqd_pkg::*;

	logic prev_a_q;
	logic accept;

	assign in_ready = q_ready;
	assign q_valid  = in_valid;
	assign accept   = in_valid & q_ready;

	// Classify the A edge against the previous tick
	always_comb begin
		q_item.enc_a       = in_data[0];
		q_item.enc_b       = in_data[1];
		q_item.button_in   = in_data[2];
		q_item.acknowledge = in_data[3];
		q_item.rise        = ~prev_a_q & in_data[0];
		q_item.fall        = prev_a_q & ~in_data[0];
	end

	// Track A on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= 1'b0;
		end else if (accept) begin
			prev_a_q <= in_data[0];
		end
	end

endmodule

// ----- sv/dqd_queue.sv -----
`timescale 1ns / 1ps
module dqd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  dqd_pkg::dqd_item_t push_item,
	output logic               push_ready,
	output logic               pop_valid,
	output dqd_pkg::dqd_item_t pop_item,
	input  logic               pop_ready
);
	import dqd_pkg::*;

	dqd_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	// Store an entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/dqd_back.sv -----
`timescale 1ns / 1ps
module dqd_back #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [dqd_pkg::TICK_WIDTH-1:0]      cfg_data,
	input  logic                                q_valid,
	input  dqd_pkg::dqd_item_t                  q_item,
	output logic                                q_ready,
	output logic                                out_valid,
	output logic [dqd_pkg::OUT_TDATA_W-1:0]     out_data,
	input  logic                                out_ready
);
	import dqd_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	logic [TICK_WIDTH-1:0]  debounce_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] ref_q;
	logic                   pol_q;
	logic                   pend_q;
	logic [TICK_WIDTH-1:0]  wt_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                   pop;
	logic [TICK_WIDTH-1:0]  wt_inc;
	logic                   fire;
	logic                   armed;
	logic [COUNT_WIDTH-1:0] cnt_nxt;
	logic [COUNT_WIDTH-1:0] ref_mid;
	logic                   pol_nxt;
	logic                   pend_nxt;
	logic [TICK_WIDTH-1:0]  wt_nxt;
	logic [POS_WIDTH-1:0]   pos;

	assign q_ready   = ~out_valid_q | out_ready;
	assign pop       = q_valid & q_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Step the debounce wait and the position for one tick
	always_comb begin
		wt_inc   = (wt_q != TICK_MAX) ? (wt_q + 16'd1) : wt_q;
		fire     = pend_q & (wt_inc >= debounce_q);
		armed    = ~pend_q & (pol_q ? q_item.fall : q_item.rise);
		cnt_nxt  = cnt_q;
		ref_mid  = ref_q;
		pol_nxt  = pol_q;
		pend_nxt = pend_q;
		wt_nxt   = wt_q;
		if (pend_q) begin
			wt_nxt = wt_inc;
			if (fire) begin
				ref_mid  = cnt_q;
				cnt_nxt  = (q_item.enc_a != q_item.enc_b) ? (cnt_q + CNT_ONE)
					: (cnt_q - CNT_ONE);
				pol_nxt  = ~pol_q;
				pend_nxt = 1'b0;
				wt_nxt   = '0;
			end
		end else if (armed) begin
			pend_nxt = 1'b1;
			wt_nxt   = '0;
		end
	end

	// Fit the count to the 16-bit position field
	if (COUNT_WIDTH >= POS_WIDTH) begin : g_pos_trunc
		assign pos = cnt_nxt[POS_WIDTH-1:0];
	end else begin : g_pos_ext
		assign pos = POS_WIDTH'($signed(cnt_nxt));
	end

	// Hold the debounce register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid) begin
			debounce_q <= cfg_data;
		end
	end

	// Commit decoder state on each popped request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ref_q  <= '0;
			pol_q  <= 1'b0;
			pend_q <= 1'b0;
			wt_q   <= '0;
		end else if (pop) begin
			cnt_q  <= cnt_nxt;
			ref_q  <= q_item.acknowledge ? cnt_nxt : ref_mid;
			pol_q  <= pol_nxt;
			pend_q <= pend_nxt;
			wt_q   <= wt_nxt;
		end
	end

	// Output register: load on pop, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {4'd0,
				q_item.button_in,
				($signed(cnt_nxt) < $signed(ref_mid)),
				($signed(ref_mid) < $signed(cnt_nxt)),
				(cnt_nxt != ref_mid),
				pos};
		end
	end

	`include "debounced_quadrature_decoder_top_assert.svh"

	`DQD_ASSERT(a_idle_wait_clear, (!pend_q |-> (wt_q == '0)), "wait count set while idle")
	`DQD_ASSERT(a_pop_loads_out, (pop |=> out_valid_q), "popped request left no result")
	`DQD_ASSERT(a_step_flips_pol, ((cnt_q != $past(cnt_q)) |-> (pol_q != $past(pol_q))), "step without polarity flip")
	`DQD_ASSERT(a_stall_holds, ((out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_data_q))), "stalled result changed")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

	typedef enum logic {WATCH_RISE, WATCH_FALL} watch_edge_t;

	typedef struct {
		logic enc_a;
		logic enc_b;
		logic button_in;
		logic acknowledge;
	} tick_t;

	typedef struct {
		logic [dqd_pkg::POS_WIDTH-1:0] position;
		logic                          changed;
		logic                          clockwise;
		logic                          counterclockwise;
		logic                          button_level;
	} decoder_out_t;

	localparam int CYCLE_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [dqd_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [dqd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dqd_pkg::TICK_WIDTH-1:0] cfg_data = '0;

	debounced_quadrature_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Decoder state as the block should hold it
	logic [dqd_pkg::TICK_WIDTH-1:0] debounce_cfg = dqd_pkg::DEBOUNCE_RESET;
	logic [dqd_pkg::POS_WIDTH-1:0]  step_pos = '0;
	logic [dqd_pkg::POS_WIDTH-1:0]  ref_pos = '0;
	logic                           last_a = 1'b0;
	watch_edge_t                    watch = WATCH_RISE;
	logic                           armed = 1'b0;
	logic [dqd_pkg::TICK_WIDTH-1:0] wait_cnt = '0;

	tick_t        pending_ticks[$];
	decoder_out_t due_outputs[$];
	int           fails = 0;

	// Advance the decoder by one tick and queue the output it must produce
	function automatic void step_decoder(input tick_t t);
		decoder_out_t o;
		logic         edge_seen;
		if (armed) begin
			if (wait_cnt != dqd_pkg::TICK_MAX)
				wait_cnt++;
			if (wait_cnt >= debounce_cfg) begin
				ref_pos = step_pos;
				step_pos = (t.enc_a != t.enc_b) ? step_pos + 16'd1 : step_pos - 16'd1;
				watch = (watch == WATCH_RISE) ? WATCH_FALL : WATCH_RISE;
				armed = 1'b0;
				wait_cnt = '0;
			end
		end else begin
			edge_seen = (watch == WATCH_RISE) ? (!last_a && t.enc_a) : (last_a && !t.enc_a);
			if (edge_seen) begin
				armed = 1'b1;
				wait_cnt = '0;
			end
		end
		last_a = t.enc_a;
		o.position = step_pos;
		o.changed = step_pos != ref_pos;
		o.clockwise = $signed(ref_pos) < $signed(step_pos);
		o.counterclockwise = $signed(step_pos) < $signed(ref_pos);
		o.button_level = t.button_in;
		// The acknowledge lands after the output is formed
		if (t.acknowledge)
			ref_pos = step_pos;
		due_outputs.push_back(o);
	endfunction

	// Sender: bursts of requests separated by random gaps
	tick_t cur_tick;
	int    burst_left = 1;
	int    gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				step_decoder(cur_tick);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_ticks.size() > 0) begin
					cur_tick = pending_ticks.pop_front();
					s_axis_tdata <= {4'b0000, cur_tick.acknowledge, cur_tick.button_in,
						cur_tick.enc_b, cur_tick.enc_a};
					s_axis_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern switches between free, choppy and mostly blocked
	int stall_mode = 0;
	int mode_left = 0;
	decoder_out_t want;
	decoder_out_t got;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.position = m_axis_tdata[15:0];
				got.changed = m_axis_tdata[16];
				got.clockwise = m_axis_tdata[17];
				got.counterclockwise = m_axis_tdata[18];
				got.button_level = m_axis_tdata[19];
				if (due_outputs.size() == 0) begin
					$error("output with no request outstanding: tdata %h", m_axis_tdata);
					fails++;
				end else begin
					want = due_outputs.pop_front();
					if (got.position !== want.position) begin
						$error("position expected %0d actual %0d",
							$signed(want.position), $signed(got.position));
						fails++;
					end
					if (got.changed !== want.changed) begin
						$error("changed expected %0b actual %0b", want.changed, got.changed);
						fails++;
					end
					if (got.clockwise !== want.clockwise) begin
						$error("clockwise expected %0b actual %0b", want.clockwise, got.clockwise);
						fails++;
					end
					if (got.counterclockwise !== want.counterclockwise) begin
						$error("counterclockwise expected %0b actual %0b",
							want.counterclockwise, got.counterclockwise);
						fails++;
					end
					if (got.button_level !== want.button_level) begin
						$error("button_level expected %0b actual %0b",
							want.button_level, got.button_level);
						fails++;
					end
				end
			end
			if (mode_left <= 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Watchdog
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Stimulus generation: current encoder levels
	logic lvl_a = 1'b0;
	logic lvl_b = 1'b0;
	logic lvl_btn = 1'b0;

	task automatic ticks(input int n, input logic a, input logic b, input logic btn,
			input logic ack);
		tick_t t;
		for (int i = 0; i < n; i++) begin
			t.enc_a = a;
			t.enc_b = b;
			t.button_in = btn;
			t.acknowledge = ack;
			pending_ticks.push_back(t);
		end
		lvl_a = a;
		lvl_b = b;
		lvl_btn = btn;
	endtask

	// Hold the current levels, with a sparse acknowledge
	task automatic hold(input int n);
		for (int i = 0; i < n; i++)
			ticks(1, lvl_a, lvl_b, lvl_btn, $urandom_range(0, 7) == 0);
	endtask

	// Wait until every request has been sent and has produced its output
	task automatic drain();
		while (pending_ticks.size() != 0 || s_axis_tvalid || due_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_debounce(input logic [dqd_pkg::TICK_WIDTH-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		debounce_cfg = v;
	endtask

	// Mostly clean quadrature detents, with bounce and noise mixed in
	task automatic rotate_random(input int n, input int deb);
		int  made;
		int  pick;
		int  len;
		logic cw;
		made = 0;
		cw = $urandom_range(0, 1);
		while (made < n) begin
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				if ($urandom_range(0, 5) == 0)
					cw = ~cw;
				// Gray step in the chosen direction
				if (cw == (lvl_a == lvl_b))
					lvl_a = ~lvl_a;
				else
					lvl_b = ~lvl_b;
				len = $urandom_range(1, deb + 3);
				hold(len);
			end else if (pick == 7) begin
				len = $urandom_range(1, 2);
				ticks(len, ~lvl_a, lvl_b, lvl_btn, 1'b0);
				ticks(1, ~lvl_a, lvl_b, lvl_btn, $urandom_range(0, 1));
				len++;
			end else if (pick == 8) begin
				lvl_btn = ~lvl_btn;
				len = $urandom_range(1, 4);
				hold(len);
			end else begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					ticks(1, $urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom_range(0, 1));
			end
			made += len;
		end
	endtask

	initial begin
		int deb_list[7];
		deb_list = '{1, 3, 2, 7, 4, 12, 1};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Default debounce: rising edge with A ahead, bounce during the wait
		ticks(1, 0, 0, 0, 0);
		ticks(1, 1, 0, 1, 0);
		ticks(1, 0, 0, 1, 0);
		ticks(2, 1, 0, 0, 0);
		ticks(1, 1, 1, 0, 0);
		ticks(1, 1, 0, 1, 1);
		// Falling edge with both low steps back
		ticks(1, 0, 0, 0, 0);
		ticks(5, 0, 0, 1, 0);
		ticks(1, 1, 1, 0, 0);
		ticks(4, 1, 1, 0, 0);
		ticks(1, 1, 1, 1, 1);
		ticks(1, 0, 1, 1, 0);
		ticks(5, 0, 1, 0, 0);
		ticks(1, 0, 1, 0, 1);
		write_debounce(16'd1);

		// Edge on the firing tick is not seen
		ticks(1, 1, 0, 0, 0);
		ticks(1, 0, 0, 1, 0);
		ticks(2, 0, 0, 1, 0);
		ticks(1, 1, 1, 0, 0);
		ticks(1, 0, 1, 0, 1);
		write_debounce(16'd0);

		// Zero debounce fires on the tick after the edge
		ticks(1, 1, 0, 1, 0);
		ticks(1, 1, 0, 1, 0);
		ticks(1, 0, 0, 0, 0);
		ticks(1, 0, 1, 0, 0);
		ticks(1, 1, 1, 1, 1);
		ticks(1, 1, 1, 0, 0);

		// Lower the debounce while a wait is running past the new value
		write_debounce(16'hFFFF);
		ticks(1, 0, 0, 0, 0);
		ticks(1, 1, 0, 0, 0);
		hold(40);
		write_debounce(16'd2);
		ticks(1, 1, 0, 1, 0);
		hold(3);

		// Random detent traffic over several debounce settings
		foreach (deb_list[i]) begin
			write_debounce(16'(deb_list[i]));
			rotate_random(45, deb_list[i]);
		end
		drain();
		rotate_random(20, 1);

		// Long debounce: noise on both channels while the wait runs
		write_debounce(16'd40);
		ticks(1, 0, 0, 0, 0);
		ticks(1, 1, 0, 0, 0);
		ticks(1, 0, 0, 0, 0);
		ticks(1, 1, 1, 0, 0);
		for (int i = 0; i < 44; i++)
			ticks(1, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 15) == 0);

		write_debounce(dqd_pkg::DEBOUNCE_RESET);
		rotate_random(60, 5);

		drain();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
